// ===== src/sparse_kernel_patch_accumulate_core_macros.svh =====
// ----------------------------------------------------------------------------
// Sparse kernel patch accumulate: assertion macros
// Concurrent assertion wrappers. They compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SPARSE_KERNEL_PATCH_ACCUMULATE_CORE_MACROS_SVH
`define SPARSE_KERNEL_PATCH_ACCUMULATE_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SKPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SKPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SKPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SKPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/skpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse kernel patch accumulate: package
// Field widths, operation and status codes, and transfer payload types.
// ----------------------------------------------------------------------------
package skpa_pkg;

    localparam int IDX_W  = 16;
    localparam int VAL_W  = 32;
    localparam int MASK_W = 8;
    localparam int FILT_W = 3;

    localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;

    localparam logic [1:0] OP_WR_WEIGHT = 2'd0;
    localparam logic [1:0] OP_WR_PIXEL  = 2'd1;
    localparam logic [1:0] OP_ADD_COEF  = 2'd2;
    localparam logic [1:0] OP_RD_PIXEL  = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_MASKED  = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;
    localparam logic [1:0] STAT_END     = 2'd3;

    localparam logic [2:0] CMD_NOP  = 3'd0;
    localparam logic [2:0] CMD_WR_W = 3'd1;
    localparam logic [2:0] CMD_WR_P = 3'd2;
    localparam logic [2:0] CMD_RD_P = 3'd3;
    localparam logic [2:0] CMD_ADD  = 3'd4;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [IDX_W-1:0] index;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [1:0]              status;
    } result_t;

    typedef struct packed {
        logic [2:0]              kind;
        logic [1:0]              status;
        logic [IDX_W-1:0]        addr;
        logic signed [VAL_W-1:0] value;
        logic [FILT_W-1:0]       filt;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
    } cmd_t;

endpackage

// ===== src/skpa_fifo.sv =====
// ----------------------------------------------------------------------------
// Sparse kernel patch accumulate: small queue
// Register-based FIFO used between front and back and on the result side.
// ----------------------------------------------------------------------------
module skpa_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    T                slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CNTW'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CNTW'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/skpa_front.sv =====
// ----------------------------------------------------------------------------
// Sparse kernel patch accumulate: front end
// Accepts items, tracks the end-of-list flag and filter mask, decodes add
// locations into filter, row and column (reciprocal multiply for the row).
// ----------------------------------------------------------------------------
`include "sparse_kernel_patch_accumulate_core_macros.svh"

module skpa_front #(
    parameter int IMAGE_SIDE  = 64,
    parameter int KERNEL_SIDE = 9,
    parameter int NUM_FILTERS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  skpa_pkg::item_t               item,
    output logic                          full,
    input  logic                          cfg_we,
    input  logic [skpa_pkg::MASK_W-1:0]   cfg_wdata,
    output logic                          cmd_push,
    output skpa_pkg::cmd_t                cmd_data,
    input  logic                          cmd_full
);

    localparam int IMG_CELLS = IMAGE_SIDE * IMAGE_SIDE;
    localparam int KER_CELLS = NUM_FILTERS * KERNEL_SIDE * KERNEL_SIDE;
    localparam int QW        = (IMAGE_SIDE > 1) ? $clog2(IMAGE_SIDE) : 1;
    localparam int RW        = skpa_pkg::IDX_W;
    // exact for offsets below 2^15
    localparam int DIV_S     = 15 + $clog2(IMAGE_SIDE);
    localparam logic [16:0] RECIP = 17'(((1 << DIV_S) + IMAGE_SIDE - 1) / IMAGE_SIDE);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_COL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]                        state_reg;
    logic                              ended_reg;
    logic [skpa_pkg::MASK_W-1:0]       mask_reg;
    logic [RW-1:0]                     r_reg;
    logic [QW-1:0]                     q_reg;
    logic [RW-1:0]                     rem_reg;
    logic [skpa_pkg::FILT_W-1:0]       filt_reg;
    logic signed [skpa_pkg::VAL_W-1:0] coef_reg;

    logic                              accept;
    logic                              go_div;
    logic                              ended_next;
    logic [3:0]                        f_c;
    logic [RW-1:0]                     rem_c;
    skpa_pkg::cmd_t                    cls;
    skpa_pkg::cmd_t                    hold;
    logic [31:0]                       q_prod;
    logic [RW-1:0]                     q_side;
    logic [RW-1:0]                     r_next;
    logic [QW-1:0]                     q_next;

    assign full   = (state_reg != F_IDLE) || cmd_full;
    assign accept = push && !full;

    always_comb
    begin
        logic [14:0] loc;
        loc        = item.index[14:0];
        f_c        = '0;
        rem_c      = {1'b0, loc};
        for (int k = 1; k <= NUM_FILTERS; k++)
        begin
            if (32'(loc) >= 32'(k * IMG_CELLS))
            begin
                f_c   = 4'(k);
                rem_c = RW'(32'(loc) - 32'(k * IMG_CELLS));
            end
        end

        cls        = '0;
        cls.kind   = skpa_pkg::CMD_NOP;
        cls.status = skpa_pkg::STAT_DONE;
        cls.addr   = item.index;
        cls.value  = item.value;
        go_div     = 1'b0;
        ended_next = ended_reg;

        unique case (item.op)
            skpa_pkg::OP_WR_WEIGHT:
            begin
                if (!item.index[15] && (32'(item.index[14:0]) < 32'(KER_CELLS)))
                begin
                    cls.kind = skpa_pkg::CMD_WR_W;
                end
            end
            skpa_pkg::OP_WR_PIXEL:
            begin
                ended_next = 1'b0;
                if (!item.index[15] && (32'(item.index[14:0]) < 32'(IMG_CELLS)))
                begin
                    cls.kind = skpa_pkg::CMD_WR_P;
                end
            end
            skpa_pkg::OP_RD_PIXEL:
            begin
                if (!item.index[15] && (32'(item.index[14:0]) < 32'(IMG_CELLS)))
                begin
                    cls.kind = skpa_pkg::CMD_RD_P;
                end
            end
            skpa_pkg::OP_ADD_COEF:
            begin
                if (ended_reg)
                begin
                    cls.status = skpa_pkg::STAT_IGNORED;
                end
                else if (item.index[15])
                begin
                    cls.status = skpa_pkg::STAT_END;
                    ended_next = 1'b1;
                end
                else if ((32'(f_c) >= 32'(NUM_FILTERS)) || !mask_reg[f_c[2:0]])
                begin
                    cls.status = skpa_pkg::STAT_MASKED;
                end
                else
                begin
                    go_div = 1'b1;
                end
            end
            default:
            begin
                cls.kind = skpa_pkg::CMD_NOP;
            end
        endcase
    end

    // row by reciprocal multiply, then column from the remainder
    assign q_prod = {17'b0, rem_reg[14:0]} * {15'b0, RECIP};
    assign q_next = QW'(q_prod >> DIV_S);
    assign q_side = RW'(32'(q_reg) * 32'(IMAGE_SIDE));
    assign r_next = rem_reg - q_side;

    always_comb
    begin
        hold        = '0;
        hold.kind   = skpa_pkg::CMD_ADD;
        hold.status = skpa_pkg::STAT_DONE;
        hold.addr   = rem_reg;
        hold.value  = coef_reg;
        hold.filt   = filt_reg;
        hold.row    = RW'(q_reg);
        hold.col    = r_reg;
    end

    assign cmd_push = ((state_reg == F_IDLE) && accept && !go_div)
                   || ((state_reg == F_PUSH) && !cmd_full);
    assign cmd_data = (state_reg == F_PUSH) ? hold : cls;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            ended_reg <= 1'b0;
            mask_reg  <= skpa_pkg::MASK_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        ended_reg <= ended_next;
                        if (go_div)
                        begin
                            state_reg <= F_DIV;
                        end
                    end
                end
                F_DIV:
                begin
                    state_reg <= F_COL;
                end
                F_COL:
                begin
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == F_IDLE) && accept && go_div)
        begin
            rem_reg  <= rem_c;
            filt_reg <= f_c[2:0];
            coef_reg <= item.value;
        end
        else if (state_reg == F_DIV)
        begin
            q_reg <= q_next;
        end
        else if (state_reg == F_COL)
        begin
            r_reg <= r_next;
        end
    end

    `SKPA_ASSERT_IMP(a_cmd_room, clk, rst_n, cmd_push, !cmd_full, "command pushed into full queue")
    `SKPA_ASSERT_NXT(a_div_end, clk, rst_n, state_reg == F_DIV, state_reg == F_COL, "decode stalled")

endmodule

// ===== src/skpa_back.sv =====
// ----------------------------------------------------------------------------
// Sparse kernel patch accumulate: back end
// Holds image and kernel memories and runs the patch read-modify-write
// pipeline: read, multiply, saturating add and write back.
// ----------------------------------------------------------------------------
`include "sparse_kernel_patch_accumulate_core_macros.svh"

module skpa_back #(
    parameter int IMAGE_SIDE  = 64,
    parameter int KERNEL_SIDE = 9,
    parameter int NUM_FILTERS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  skpa_pkg::cmd_t    cmd_data,
    output logic              cmd_pop,
    input  logic              res_full,
    output logic              res_push,
    output skpa_pkg::result_t res_data
);

    localparam int IMG_CELLS = IMAGE_SIDE * IMAGE_SIDE;
    localparam int KK        = KERNEL_SIDE * KERNEL_SIDE;
    localparam int KER_CELLS = NUM_FILTERS * KK;
    localparam int AW        = (IMG_CELLS > 1) ? $clog2(IMG_CELLS) : 1;
    localparam int WAW       = (KER_CELLS > 1) ? $clog2(KER_CELLS) : 1;
    localparam int KW        = (KERNEL_SIDE > 1) ? $clog2(KERNEL_SIDE) : 1;
    localparam int HALF      = KERNEL_SIDE / 2;
    localparam int CRW       = $clog2(IMAGE_SIDE + KERNEL_SIDE) + 2;
    localparam int PSW       = $clog2(IMG_CELLS + 2 * KERNEL_SIDE * IMAGE_SIDE + 2) + 2;
    localparam int ROW_STEP  = IMAGE_SIDE - KERNEL_SIDE + 1;
    localparam int VW        = skpa_pkg::VAL_W;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_WALK  = 2'd1;
    localparam logic [1:0] B_DRAIN = 2'd2;
    localparam logic [1:0] B_READ  = 2'd3;

    logic signed [VW-1:0]  img_mem [IMG_CELLS];
    logic signed [VW-1:0]  wgt_mem [KER_CELLS];

    logic [1:0]            state_reg;
    logic [KW-1:0]         kx_reg;
    logic [KW-1:0]         ky_reg;
    logic signed [CRW-1:0] xr_reg;
    logic signed [CRW-1:0] yr_reg;
    logic signed [CRW-1:0] xs_reg;
    logic signed [PSW-1:0] pa_reg;
    logic [WAW-1:0]        wa_reg;
    logic signed [VW-1:0]  coef_reg;

    logic                  v1_reg;
    logic [AW-1:0]         a1_reg;
    logic                  v2_reg;
    logic [AW-1:0]         a2_reg;
    logic signed [VW-1:0]  pix2_reg;
    logic signed [63:0]    prod_reg;
    logic signed [VW-1:0]  img_rd_reg;
    logic signed [VW-1:0]  wgt_rd_reg;

    logic                  step_ok;
    logic                  last_step;
    logic                  idle_take;
    logic                  img_we;
    logic [AW-1:0]         img_waddr;
    logic signed [VW-1:0]  img_wdata;
    logic [AW-1:0]         img_raddr;
    logic                  wgt_we;
    logic [48:0]           sum;
    logic signed [VW-1:0]  sat;

    assign idle_take = (state_reg == B_IDLE) && !cmd_empty && !res_full;
    assign cmd_pop   = idle_take;

    assign step_ok   = (yr_reg >= 0) && (yr_reg < $signed(CRW'(IMAGE_SIDE)))
                    && (xr_reg >= 0) && (xr_reg < $signed(CRW'(IMAGE_SIDE)));
    assign last_step = (kx_reg == KW'(KERNEL_SIDE - 1)) && (ky_reg == KW'(KERNEL_SIDE - 1));

    // pixel + (coef * weight) >> 16, saturated to 32 bits
    assign sum = {{17{pix2_reg[31]}}, pix2_reg} + {prod_reg[63], prod_reg[63:16]};
    always_comb
    begin
        if (sum[48:31] == '0 || sum[48:31] == '1)
        begin
            sat = sum[31:0];
        end
        else if (sum[48])
        begin
            sat = 32'sh8000_0000;
        end
        else
        begin
            sat = 32'sh7FFF_FFFF;
        end
    end

    assign wgt_we    = idle_take && (cmd_data.kind == skpa_pkg::CMD_WR_W);
    assign img_we    = v2_reg || (idle_take && (cmd_data.kind == skpa_pkg::CMD_WR_P));
    assign img_waddr = v2_reg ? a2_reg : AW'(cmd_data.addr);
    assign img_wdata = v2_reg ? sat : cmd_data.value;
    assign img_raddr = (state_reg == B_WALK) ? AW'(pa_reg) : AW'(cmd_data.addr);

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_waddr] <= img_wdata;
        end
        img_rd_reg <= img_mem[img_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            wgt_mem[WAW'(cmd_data.addr)] <= cmd_data.value;
        end
        wgt_rd_reg <= wgt_mem[wa_reg];
    end

    always_ff @(posedge clk)
    begin
        a1_reg   <= AW'(pa_reg);
        a2_reg   <= a1_reg;
        pix2_reg <= img_rd_reg;
        prod_reg <= coef_reg * wgt_rd_reg;
    end

    always_comb
    begin
        res_push = 1'b0;
        res_data = '0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (idle_take && (cmd_data.kind != skpa_pkg::CMD_ADD)
                    && (cmd_data.kind != skpa_pkg::CMD_RD_P))
                begin
                    res_push        = 1'b1;
                    res_data.status = cmd_data.status;
                end
            end
            B_READ:
            begin
                res_push            = 1'b1;
                res_data.read_value = img_rd_reg;
                res_data.status     = skpa_pkg::STAT_DONE;
            end
            B_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    res_push        = 1'b1;
                    res_data.status = skpa_pkg::STAT_DONE;
                end
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            v1_reg <= (state_reg == B_WALK) && step_ok;
            v2_reg <= v1_reg;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (idle_take)
                    begin
                        if (cmd_data.kind == skpa_pkg::CMD_ADD)
                        begin
                            state_reg <= B_WALK;
                        end
                        else if (cmd_data.kind == skpa_pkg::CMD_RD_P)
                        begin
                            state_reg <= B_READ;
                        end
                    end
                end
                B_WALK:
                begin
                    if (last_step)
                    begin
                        state_reg <= B_DRAIN;
                    end
                end
                B_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_READ:
                begin
                    state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // patch walk counters
    always_ff @(posedge clk)
    begin
        if (idle_take && (cmd_data.kind == skpa_pkg::CMD_ADD))
        begin
            kx_reg   <= '0;
            ky_reg   <= '0;
            xr_reg   <= $signed(CRW'(cmd_data.col)) - $signed(CRW'(HALF));
            xs_reg   <= $signed(CRW'(cmd_data.col)) - $signed(CRW'(HALF));
            yr_reg   <= $signed(CRW'(cmd_data.row)) - $signed(CRW'(HALF));
            pa_reg   <= $signed(PSW'(cmd_data.addr)) - $signed(PSW'(HALF * IMAGE_SIDE + HALF));
            wa_reg   <= WAW'(32'(cmd_data.filt) * KK);
            coef_reg <= cmd_data.value;
        end
        else if (state_reg == B_WALK)
        begin
            wa_reg <= WAW'(wa_reg + 1'b1);
            if (kx_reg == KW'(KERNEL_SIDE - 1))
            begin
                kx_reg <= '0;
                ky_reg <= KW'(ky_reg + 1'b1);
                xr_reg <= xs_reg;
                yr_reg <= yr_reg + $signed(CRW'(1));
                pa_reg <= pa_reg + $signed(PSW'(ROW_STEP));
            end
            else
            begin
                kx_reg <= KW'(kx_reg + 1'b1);
                xr_reg <= xr_reg + $signed(CRW'(1));
                pa_reg <= pa_reg + $signed(PSW'(1));
            end
        end
    end

    `SKPA_ASSERT_IMP(a_pop_idle, clk, rst_n, cmd_pop, state_reg == B_IDLE, "command taken while busy")
    `SKPA_ASSERT_IMP(a_wb_in_add, clk, rst_n, v2_reg, (state_reg == B_WALK) || (state_reg == B_DRAIN), "write back outside add")
    `SKPA_ASSERT_IMP(a_res_room, clk, rst_n, res_push, !res_full, "result pushed into full queue")

endmodule

// ===== src/sparse_kernel_patch_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// Sparse kernel patch accumulate core
// Scatter-adds coefficient-scaled kernels into a residual image.
//
//   channel   direction  transfer when         payload
//   item      in         push && !full        skpa_pkg::item_t
//   result    out        pop && !empty        skpa_pkg::result_t
//   cfg       in         cfg_we               filter enable mask
//
// Add: the back end walks the KERNEL_SIDE^2 patch (one pixel
// read-modify-write per cycle on the image memory port); location decode
// in the front (F_DIV, F_COL, F_PUSH) overlaps earlier work. No clearing
// pass; memories hold garbage until written. Two-entry queues sit between
// front, back and result side.
// ----------------------------------------------------------------------------
module sparse_kernel_patch_accumulate_core #(
    parameter int IMAGE_SIDE  = 64,
    parameter int KERNEL_SIDE = 9,
    parameter int NUM_FILTERS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  skpa_pkg::item_t             item,
    output logic                        empty,
    input  logic                        pop,
    output skpa_pkg::result_t           result,
    input  logic                        cfg_we,
    input  logic [skpa_pkg::MASK_W-1:0] cfg_wdata
);

    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_empty;
    skpa_pkg::cmd_t    cmd_wdata;
    skpa_pkg::cmd_t    cmd_rdata;
    logic              res_push;
    logic              res_full;
    skpa_pkg::result_t res_wdata;

    skpa_front #(
        .IMAGE_SIDE  (IMAGE_SIDE),
        .KERNEL_SIDE (KERNEL_SIDE),
        .NUM_FILTERS (NUM_FILTERS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_wdata),
        .cmd_full  (cmd_full)
    );

    skpa_fifo #(
        .T     (skpa_pkg::cmd_t),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    skpa_back #(
        .IMAGE_SIDE  (IMAGE_SIDE),
        .KERNEL_SIDE (KERNEL_SIDE),
        .NUM_FILTERS (NUM_FILTERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_rdata),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    skpa_fifo #(
        .T     (skpa_pkg::result_t),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse kernel patch accumulate: block-level testbench
// Feeds weight, pixel, add and read items through the push/full side and
// checks every result transfer against an in-bench scatter-add predictor.
// Stimulus only reads pixels and weights it has written before. Both sides
// idle at random, the filter mask is rewritten between drained phases, and
// one phase holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IMG_SIDE    = 64;
    localparam int KER_SIDE    = 9;
    localparam int FILTERS     = 8;
    localparam int HALF        = KER_SIDE / 2;
    localparam int IMG_CELLS   = IMG_SIDE * IMG_SIDE;
    localparam int KER_AREA    = KER_SIDE * KER_SIDE;
    localparam int KER_CELLS   = FILTERS * KER_AREA;
    localparam int PHASE_ITEMS = 220;
    localparam int HOLD_CYCLES = 700;
    localparam int TAIL_CYCLES = 150;
    localparam int LIMIT_NS    = 8_000_000;
    localparam longint SAT_HI  = 64'sd2147483647;
    localparam longint SAT_LO  = -64'sd2147483648;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        push      = 1'b0;
    logic                        full;
    skpa_pkg::item_t             item      = '0;
    logic                        empty;
    logic                        pop       = 1'b0;
    skpa_pkg::result_t           result;
    logic                        cfg_we    = 1'b0;
    logic [skpa_pkg::MASK_W-1:0] cfg_wdata = '0;

    // predictor state
    logic signed [skpa_pkg::VAL_W-1:0] image_mem  [IMG_CELLS];
    logic signed [skpa_pkg::VAL_W-1:0] kernel_mem [KER_CELLS];
    logic                              list_done = 1'b0;
    logic [skpa_pkg::MASK_W-1:0]       filt_mask = skpa_pkg::MASK_RESET;

    // stimulus bookkeeping
    skpa_pkg::item_t   item_queue[$];
    skpa_pkg::result_t expected_results[$];
    bit                px_set [IMG_CELLS];
    bit                wt_set [KER_CELLS];
    int                px_list[$];
    int                items_made   = 0;
    int                results_seen = 0;
    int                fail_count   = 0;

    // handshake pacing
    int   send_gap   = 0;
    int   recv_gap   = 0;
    int   recv_draw  = 0;
    bit   send_calm  = 1'b0;
    bit   recv_calm  = 1'b0;
    bit   hold_go    = 1'b0;
    logic drain_hold = 1'b0;

    sparse_kernel_patch_accumulate_core #(
        .IMAGE_SIDE  (IMG_SIDE),
        .KERNEL_SIDE (KER_SIDE),
        .NUM_FILTERS (FILTERS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    function automatic skpa_pkg::result_t apply_item(skpa_pkg::item_t it);
        skpa_pkg::result_t res;
        int      idx, f, rem, iy, ix, y0, y1, x0, x1, yr, xr, wa, pa;
        longint  coef, prod, acc;
        res  = '0;
        idx  = $signed(it.index);
        coef = $signed(it.value);
        case (it.op)
            skpa_pkg::OP_WR_WEIGHT:
            begin
                if (idx >= 0 && idx < KER_CELLS)
                    kernel_mem[idx] = it.value;
            end
            skpa_pkg::OP_WR_PIXEL:
            begin
                if (idx >= 0 && idx < IMG_CELLS)
                    image_mem[idx] = it.value;
                list_done = 1'b0;
            end
            skpa_pkg::OP_ADD_COEF:
            begin
                if (list_done)
                    res.status = skpa_pkg::STAT_IGNORED;
                else if (idx < 0)
                begin
                    list_done  = 1'b1;
                    res.status = skpa_pkg::STAT_END;
                end
                else
                begin
                    f   = idx / IMG_CELLS;
                    rem = idx % IMG_CELLS;
                    iy  = rem / IMG_SIDE;
                    ix  = rem % IMG_SIDE;
                    if (f >= FILTERS || !filt_mask[f])
                        res.status = skpa_pkg::STAT_MASKED;
                    else
                    begin
                        y0 = (iy - HALF < 0) ? 0 : iy - HALF;
                        y1 = (iy - HALF + KER_SIDE - 1 > IMG_SIDE - 1) ?
                             IMG_SIDE - 1 : iy - HALF + KER_SIDE - 1;
                        x0 = (ix - HALF < 0) ? 0 : ix - HALF;
                        x1 = (ix - HALF + KER_SIDE - 1 > IMG_SIDE - 1) ?
                             IMG_SIDE - 1 : ix - HALF + KER_SIDE - 1;
                        for (yr = y0; yr <= y1; yr++)
                        begin
                            for (xr = x0; xr <= x1; xr++)
                            begin
                                wa   = f * KER_AREA + (yr + HALF - iy) * KER_SIDE
                                     + (xr + HALF - ix);
                                pa   = yr * IMG_SIDE + xr;
                                prod = (coef * longint'(kernel_mem[wa])) >>> 16;
                                acc  = longint'(image_mem[pa]) + prod;
                                if (acc > SAT_HI)
                                    image_mem[pa] = 32'h7FFF_FFFF;
                                else if (acc < SAT_LO)
                                    image_mem[pa] = 32'h8000_0000;
                                else
                                    image_mem[pa] = acc[31:0];
                            end
                        end
                        res.status = skpa_pkg::STAT_DONE;
                    end
                end
            end
            default:
            begin
                if (idx >= 0 && idx < IMG_CELLS)
                    res.read_value = image_mem[idx];
            end
        endcase
        return res;
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic logic [31:0] draw_value();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            case ($urandom_range(0, 5))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h0001_0000;
                default: return 32'hFFFF_0000;
            endcase
        end
        if (pick < 3)
            return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
        return $urandom();
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("MISMATCH result %0d %s: got %h expected %h",
                     results_seen, what, got, want);
    endtask

    task automatic check_result(skpa_pkg::result_t got);
        skpa_pkg::result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected transfer", got.read_value, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
    endtask

    // input side: one item per transfer, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            item     <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_results.push_back(apply_item(item));
                if ($urandom_range(0, 39) == 0)
                    send_calm <= !send_calm;
            end
            if (!push || !full)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    push     <= 1'b0;
                end
                else if (item_queue.size() != 0)
                begin
                    item     <= item_queue.pop_front();
                    push     <= 1'b1;
                    send_gap <= draw_gap(send_calm);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            recv_gap <= 0;
        end
        else if (pop && !empty)
        begin
            check_result(result);
            if ($urandom_range(0, 39) == 0)
                recv_calm <= !recv_calm;
            recv_draw = draw_gap(recv_calm);
            recv_gap <= recv_draw;
            pop      <= (recv_draw == 0) && !drain_hold;
        end
        else if (drain_hold || recv_gap != 0)
        begin
            pop <= 1'b0;
            if (recv_gap != 0)
                recv_gap <= recv_gap - 1;
        end
        else
            pop <= 1'b1;
    end

    // long result-side hold-off, counted here
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        drain_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        drain_hold <= 1'b0;
    end

    task automatic queue_item(logic [1:0] op, int idx, logic [31:0] val);
        skpa_pkg::item_t it;
        it.op    = op;
        it.index = idx[15:0];
        it.value = val;
        item_queue.push_back(it);
        items_made++;
    endtask

    task automatic store_pixel(int a, logic [31:0] v);
        queue_item(skpa_pkg::OP_WR_PIXEL, a, v);
        if (!px_set[a])
        begin
            px_set[a] = 1'b1;
            px_list.push_back(a);
        end
    endtask

    task automatic store_weight(int a, logic [31:0] v);
        queue_item(skpa_pkg::OP_WR_WEIGHT, a, v);
        wt_set[a] = 1'b1;
    endtask

    // make sure every weight and pixel an add would touch holds data
    task automatic cover_patch(int f, int r, int c);
        int ky, kx, yr, xr, wa, pa;
        for (ky = 0; ky < KER_SIDE; ky++)
        begin
            for (kx = 0; kx < KER_SIDE; kx++)
            begin
                yr = r - HALF + ky;
                xr = c - HALF + kx;
                if (yr >= 0 && yr < IMG_SIDE && xr >= 0 && xr < IMG_SIDE)
                begin
                    wa = f * KER_AREA + ky * KER_SIDE + kx;
                    pa = yr * IMG_SIDE + xr;
                    if (!wt_set[wa])
                        store_weight(wa, draw_value());
                    if (!px_set[pa])
                        store_pixel(pa, draw_value());
                end
            end
        end
    endtask

    task automatic pick_center(output int r, output int c);
        int k;
        k = $urandom_range(0, 15);
        if (k < 5)
        begin
            r = $urandom_range(0, 4);
            c = $urandom_range(0, 4);
        end
        else if (k < 10)
        begin
            r = $urandom_range(IMG_SIDE - 5, IMG_SIDE - 1);
            c = $urandom_range(IMG_SIDE - 5, IMG_SIDE - 1);
        end
        else if (k < 13)
        begin
            r = $urandom_range(30, 33);
            c = $urandom_range(30, 33);
        end
        else if (k < 15)
        begin
            r = $urandom_range(IMG_SIDE - 4, IMG_SIDE - 1);
            c = $urandom_range(0, 3);
        end
        else
        begin
            r = $urandom_range(0, IMG_SIDE - 1);
            c = $urandom_range(0, IMG_SIDE - 1);
        end
    endtask

    task automatic add_patch(int f, int r, int c, logic [31:0] coef);
        cover_patch(f, r, c);
        queue_item(skpa_pkg::OP_ADD_COEF, f * IMG_CELLS + r * IMG_SIDE + c, coef);
    endtask

    task automatic directed_items();
        store_weight(0, 32'h7FFF_FFFF);
        store_weight(KER_CELLS - 1, 32'h8000_0000);
        queue_item(skpa_pkg::OP_WR_WEIGHT, KER_CELLS, $urandom());
        queue_item(skpa_pkg::OP_WR_WEIGHT, 32767, $urandom());
        queue_item(skpa_pkg::OP_WR_WEIGHT, -1, $urandom());
        queue_item(skpa_pkg::OP_WR_PIXEL, -1, $urandom());
        queue_item(skpa_pkg::OP_WR_PIXEL, IMG_CELLS, $urandom());
        queue_item(skpa_pkg::OP_WR_PIXEL, 32767, $urandom());
        queue_item(skpa_pkg::OP_RD_PIXEL, -1, $urandom());
        queue_item(skpa_pkg::OP_RD_PIXEL, IMG_CELLS, $urandom());
        queue_item(skpa_pkg::OP_RD_PIXEL, 32767, 32'hFFFF_FFFF);
        cover_patch(0, 0, 0);
        store_pixel(0, 32'h7FFF_FFFF);
        store_weight(HALF * KER_SIDE + HALF, 32'h7FFF_FFFF);
        queue_item(skpa_pkg::OP_ADD_COEF, 0, 32'h7FFF_FFFF);
        queue_item(skpa_pkg::OP_RD_PIXEL, 0, 32'h0);
        queue_item(skpa_pkg::OP_ADD_COEF, 0, 32'h8000_0000);
        queue_item(skpa_pkg::OP_RD_PIXEL, 0, 32'h0);
        add_patch(FILTERS - 1, IMG_SIDE - 1, IMG_SIDE - 1, 32'hFFFF_0000);
        queue_item(skpa_pkg::OP_RD_PIXEL, IMG_CELLS - 1, 32'h0);
        queue_item(skpa_pkg::OP_ADD_COEF, -1, 32'h0001_0000);
        queue_item(skpa_pkg::OP_ADD_COEF, 0, 32'h0001_0000);
        queue_item(skpa_pkg::OP_ADD_COEF, -1, 32'h0);
        store_pixel(1, 32'h0);
        queue_item(skpa_pkg::OP_ADD_COEF, 0, 32'h0000_8000);
        queue_item(skpa_pkg::OP_RD_PIXEL, 1, $urandom());
    endtask

    task automatic random_items(int count);
        int stop, k, f, r, c, n, idx;
        logic [1:0] op;
        stop = items_made + count;
        while (items_made < stop)
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
            begin
                f = $urandom_range(0, FILTERS - 1);
                pick_center(r, c);
                add_patch(f, r, c, draw_value());
                if ($urandom_range(0, 2) == 0)
                    queue_item(skpa_pkg::OP_RD_PIXEL, r * IMG_SIDE + c, $urandom());
            end
            else if (k < 52)
            begin
                // end of list, a few ignored adds, then usually a pixel write
                queue_item(skpa_pkg::OP_ADD_COEF, -1, draw_value());
                n = $urandom_range(0, 3);
                repeat (n)
                begin
                    idx = ($urandom_range(0, 3) == 0) ? -1 : int'($urandom_range(0, 32767));
                    queue_item(skpa_pkg::OP_ADD_COEF, idx, draw_value());
                end
                if ($urandom_range(0, 4) != 0)
                    store_pixel($urandom_range(0, IMG_CELLS - 1), draw_value());
            end
            else if (k < 67)
                queue_item(skpa_pkg::OP_RD_PIXEL,
                           px_list[$urandom_range(0, px_list.size() - 1)], $urandom());
            else if (k < 75)
                store_pixel($urandom_range(0, IMG_CELLS - 1), draw_value());
            else if (k < 83)
                store_weight($urandom_range(0, KER_CELLS - 1), draw_value());
            else
            begin
                op  = 2'($urandom_range(0, 3));
                idx = -1;
                case (op)
                    skpa_pkg::OP_WR_WEIGHT:
                    begin
                        if ($urandom_range(0, 3) != 0)
                            idx = $urandom_range(KER_CELLS, 32767);
                    end
                    skpa_pkg::OP_WR_PIXEL, skpa_pkg::OP_RD_PIXEL:
                    begin
                        if ($urandom_range(0, 3) != 0)
                            idx = $urandom_range(IMG_CELLS, 32767);
                    end
                    default: idx = -1;
                endcase
                queue_item(op, idx, $urandom());
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (item_queue.size() != 0 || push || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_mask(logic [skpa_pkg::MASK_W-1:0] m);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        filt_mask = m;
    endtask

    initial
    begin
        int                          ph;
        logic [skpa_pkg::MASK_W-1:0] masks [6];
        masks[0] = 8'h00;
        masks[1] = 8'($urandom());
        masks[2] = 8'hFF;
        masks[3] = 8'($urandom());
        masks[4] = 8'h7E;
        masks[5] = 8'hFF;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        wait_drained();
        for (ph = 0; ph < 6; ph++)
        begin
            write_mask(masks[ph]);
            if (ph == 2)
                hold_go = 1'b1;
            random_items(PHASE_ITEMS);
            wait_drained();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
